// ===== hw/rtl/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg: shared types for the span clipper
// Item and result structs, command kinds, engine states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package scp_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned WallW  = 23;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_WALL_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WALL_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_HORIZ = 2'd2,
    KIND_VERT  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CoordW-1:0]  x_lo;
    logic [CoordW-1:0]  x_hi;
    logic [CoordW-1:0]  z_lo;
    logic [CoordW-1:0]  z_hi;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0]  piece_start;
    logic [CoordW-1:0]  piece_end;
    logic               has_piece;
    logic               last_piece;
    logic               openings_dropped;
  } out_item_t;

  typedef struct packed {
    logic [CoordW-1:0] x_start;
    logic [CoordW-1:0] x_end;
    logic [CoordW-1:0] z_start;
    logic [CoordW-1:0] z_end;
  } opening_t;

  typedef struct packed {
    logic [CoordW-1:0] s;
    logic [CoordW-1:0] e;
  } piece_t;

  // front -> back command handoff
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_OPEN_RD,
    ST_OPEN_EVAL,
    ST_PC_RD,
    ST_PC_EVAL,
    ST_PC_SPLIT,
    ST_EMIT_RD,
    ST_EMIT_WR
  } eng_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/span_clip_against_rectangles.sv =====
// Sequence: clear/add complete in idle; a query clips its band to the walls, reads each
//   stored opening, walks the pieces held for each opening that meets the band, and
//   then emits its results one by one.
// Flow: one transaction in flight in the clip engine, which walks its single-port
//   opening table and piece lists one entry at a time and takes no new command until done.
// Reset: synchronous active-low; clears the queues, opening count, sticky flag, walls.
// ----------------------------------------------------------------------------
// span_clip_against_rectangles: span clipper top level
// Input queue, clip engine and result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module span_clip_against_rectangles
  import scp_pkg::*;
#(
  parameter int unsigned MAX_OPENINGS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [WallW-1:0]   cfg_data,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire in_item_t           in_item,
  input  wire logic               out_pop,
  output logic                    out_empty,
  output out_item_t               out_item
);

  cmd_t      cmd;
  logic      cmd_take, res_push, res_full;
  out_item_t res_item;

  scp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  scp_back #(.MAX_OPENINGS(MAX_OPENINGS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full)
  );

  scp_out_fifo u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_item (res_item),
    .full      (res_full),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/scp_front.sv =====
// ----------------------------------------------------------------------------
// scp_front: input queue
// Two-entry command queue; decouples the input side from the clip engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scp_front
  import scp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_item,
  output cmd_t          cmd,
  input  wire logic     cmd_take
);

  in_item_t   q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign in_full   = (cnt_r == 2'd2);
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_take && (cnt_r != 2'd0);
  assign cmd.valid = (cnt_r != 2'd0);
  assign cmd.item  = q_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= in_item;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// scp_out_fifo: result queue
// Two-entry queue between the clip engine and the result ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scp_out_fifo
  import scp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t push_item,
  output logic           full,
  input  wire logic      out_pop,
  output logic           out_empty,
  output out_item_t      out_item
);

  out_item_t  q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign out_item  = q_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = out_pop && !out_empty;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= push_item;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scp_back.sv =====
// ----------------------------------------------------------------------------
// scp_back: clip engine
// Holds the opening table and walls; runs each query over ping-pong piece
// lists, one stored opening and one piece at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scp_back
  import scp_pkg::*;
#(
  parameter int unsigned MAX_OPENINGS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [WallW-1:0]   cfg_data,
  input  wire cmd_t               cmd,
  output logic                    cmd_take,
  output logic                    res_push,
  output out_item_t               res_item,
  input  wire logic               res_full
);

  localparam int unsigned PD   = MAX_OPENINGS + 1;
  localparam int unsigned OCW  = $clog2(MAX_OPENINGS + 1);
  localparam int unsigned OIW  = (MAX_OPENINGS > 1) ? $clog2(MAX_OPENINGS) : 1;
  localparam int unsigned PIW  = $clog2(PD);
  localparam int unsigned PCW  = $clog2(PD + 1);
  localparam logic [OCW-1:0] OMAX = OCW'(MAX_OPENINGS);
  localparam logic [PCW:0]   PDEP = (PCW + 1)'(PD);

  eng_state_t state_r, state_nxt;

  logic [WallW-1:0] wall_w_r, wall_h_r;
  logic [OCW-1:0]   open_cnt_r, open_cnt_nxt;
  logic             dropped_r, dropped_nxt;
  in_item_t         q_r, q_nxt;
  logic [OCW-1:0]   oi_r, oi_nxt;
  logic             bank_r, bank_nxt;
  logic [PCW-1:0]   src_n_r, src_n_nxt, dst_n_r, dst_n_nxt, j_r, j_nxt;
  logic signed [CoordW-1:0] a_r, a_nxt, b_r, b_nxt;

  opening_t op_mem [MAX_OPENINGS];
  piece_t   pa_mem [PD];
  piece_t   pb_mem [PD];
  opening_t op_rd_r;
  piece_t   pa_rd_r, pb_rd_r;

  // control
  logic           op_we, op_re, pc_re, pw_en, pw_bank;
  logic [PIW-1:0] pw_addr;
  piece_t         pw_data;

  // datapath views
  logic                     horiz;
  logic signed [CoordW-1:0] xl, xh, zl, zh, os_x, oe_x, os_z, oe_z;
  logic signed [CoordW-1:0] ps, pe, clamp_s, clamp_e, top;
  logic                     hit;
  logic [PCW:0]             cur_cnt;
  piece_t                   rd_piece;

  assign horiz    = (q_r.kind == KIND_HORIZ);
  assign xl       = $signed(q_r.x_lo);
  assign xh       = $signed(q_r.x_hi);
  assign zl       = $signed(q_r.z_lo);
  assign zh       = $signed(q_r.z_hi);
  assign os_x     = $signed(op_rd_r.x_start);
  assign oe_x     = $signed(op_rd_r.x_end);
  assign os_z     = $signed(op_rd_r.z_start);
  assign oe_z     = $signed(op_rd_r.z_end);
  assign rd_piece = bank_r ? pb_rd_r : pa_rd_r;
  assign ps       = $signed(rd_piece.s);
  assign pe       = $signed(rd_piece.e);
  assign top      = $signed({1'b0, horiz ? wall_w_r : wall_h_r});
  assign clamp_s  = (horiz ? xl : zl) < 0 ? '0 : (horiz ? xl : zl);
  assign clamp_e  = (horiz ? xh : zh) > top ? top : (horiz ? xh : zh);
  // pieces held right now: already written plus not yet visited
  assign cur_cnt  = {1'b0, dst_n_r} + {1'b0, src_n_r} - {1'b0, j_r};

  always_comb begin
    if (horiz) begin
      hit = (os_z >= zl && os_z <= zh) || (oe_z >= zl && oe_z <= zh) ||
            (os_z <= zl && oe_z >= zh);
    end else begin
      hit = (xl >= os_x && xl <= oe_x) || (xh >= os_x && xh <= oe_x) ||
            (xl <= os_x && xh >= oe_x);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.valid && (cmd.item.kind == KIND_HORIZ || cmd.item.kind == KIND_VERT))
          state_nxt = ST_INIT;
      end
      ST_INIT: state_nxt = ST_OPEN_RD;
      ST_OPEN_RD: begin
        if (oi_r == open_cnt_r)
          state_nxt = (src_n_r == '0) ? ST_EMIT_WR : ST_EMIT_RD;
        else
          state_nxt = ST_OPEN_EVAL;
      end
      ST_OPEN_EVAL: state_nxt = (hit && src_n_r != '0) ? ST_PC_RD : ST_OPEN_RD;
      ST_PC_RD:     state_nxt = (j_r == src_n_r) ? ST_OPEN_RD : ST_PC_EVAL;
      ST_PC_EVAL: begin
        if (a_r > ps && b_r < pe && cur_cnt < PDEP) state_nxt = ST_PC_SPLIT;
        else                                        state_nxt = ST_PC_RD;
      end
      ST_PC_SPLIT: state_nxt = ST_PC_RD;
      ST_EMIT_RD:  state_nxt = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (!res_full) begin
          if (src_n_r == '0 || j_r + 1'b1 == src_n_r) state_nxt = ST_IDLE;
          else                                         state_nxt = ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_take = 1'b0;
    op_we    = 1'b0;
    op_re    = 1'b0;
    pc_re    = 1'b0;
    pw_en    = 1'b0;
    pw_bank  = ~bank_r;
    pw_addr  = dst_n_r[PIW-1:0];
    pw_data  = rd_piece;
    res_push = 1'b0;
    res_item = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd_take = cmd.valid;
        op_we    = cmd.valid && cmd.item.kind == KIND_ADD && open_cnt_r < OMAX;
      end
      ST_INIT: begin
        pw_en   = 1'b1;
        pw_bank = bank_r;
        pw_addr = '0;
        pw_data = '{s: clamp_s, e: clamp_e};
      end
      ST_OPEN_RD: op_re = (oi_r != open_cnt_r);
      ST_PC_RD:   pc_re = (j_r != src_n_r);
      ST_PC_EVAL: begin
        if (a_r <= ps) begin
          pw_en   = !(b_r >= pe);
          pw_data = '{s: (b_r > ps) ? b_r : ps, e: pe};
        end else if (b_r >= pe) begin
          pw_en   = 1'b1;
          pw_data = '{s: ps, e: (a_r < pe) ? a_r : pe};
        end else begin
          pw_en = 1'b1;
          // list full: the piece is copied unchanged
          if (cur_cnt < PDEP) pw_data = '{s: ps, e: a_r};
        end
      end
      ST_PC_SPLIT: begin
        pw_en   = 1'b1;
        pw_data = '{s: b_r, e: pe};
      end
      ST_EMIT_RD: pc_re = 1'b1;
      ST_EMIT_WR: begin
        res_push = 1'b1;
        if (src_n_r == '0) begin
          res_item = '{piece_start: '0, piece_end: '0, has_piece: 1'b0,
                       last_piece: 1'b1, openings_dropped: dropped_r};
        end else begin
          res_item = '{piece_start: rd_piece.s, piece_end: rd_piece.e,
                       has_piece: 1'b1, last_piece: (j_r + 1'b1 == src_n_r),
                       openings_dropped: dropped_r};
        end
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    open_cnt_nxt = open_cnt_r;
    dropped_nxt  = dropped_r;
    q_nxt        = q_r;
    oi_nxt       = oi_r;
    bank_nxt     = bank_r;
    src_n_nxt    = src_n_r;
    dst_n_nxt    = dst_n_r;
    j_nxt        = j_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.valid) begin
          q_nxt = cmd.item;
          unique case (cmd.item.kind)
            KIND_CLEAR: open_cnt_nxt = '0;
            KIND_ADD: begin
              if (open_cnt_r < OMAX) open_cnt_nxt = open_cnt_r + 1'b1;
              else                   dropped_nxt  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        src_n_nxt = PCW'(1);
        oi_nxt    = '0;
      end
      ST_OPEN_RD: begin
        j_nxt = '0;
      end
      ST_OPEN_EVAL: begin
        a_nxt     = horiz ? os_x : os_z;
        b_nxt     = horiz ? oe_x : oe_z;
        dst_n_nxt = '0;
        j_nxt     = '0;
        if (!(hit && src_n_r != '0)) oi_nxt = oi_r + 1'b1;
      end
      ST_PC_RD: begin
        if (j_r == src_n_r) begin
          bank_nxt  = ~bank_r;
          src_n_nxt = dst_n_r;
          oi_nxt    = oi_r + 1'b1;
        end
      end
      ST_PC_EVAL: begin
        if (pw_en) dst_n_nxt = dst_n_r + 1'b1;
        if (!(a_r > ps && b_r < pe && cur_cnt < PDEP)) j_nxt = j_r + 1'b1;
      end
      ST_PC_SPLIT: begin
        dst_n_nxt = dst_n_r + 1'b1;
        j_nxt     = j_r + 1'b1;
      end
      ST_EMIT_WR: begin
        if (!res_full) j_nxt = j_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      open_cnt_r <= '0;
      dropped_r  <= 1'b0;
      wall_w_r   <= '0;
      wall_h_r   <= '0;
      bank_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      open_cnt_r <= open_cnt_nxt;
      dropped_r  <= dropped_nxt;
      bank_r     <= bank_nxt;
      if (cfg_we && cfg_index == CFG_WALL_WIDTH)  wall_w_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_WALL_HEIGHT) wall_h_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    q_r       <= q_nxt;
    oi_r      <= oi_nxt;
    src_n_r   <= src_n_nxt;
    dst_n_r   <= dst_n_nxt;
    j_r       <= j_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
  end

  // opening table
  always_ff @(posedge clk) begin
    if (op_we)
      op_mem[open_cnt_r[OIW-1:0]] <= '{x_start: cmd.item.x_lo, x_end: cmd.item.x_hi,
                                       z_start: cmd.item.z_lo, z_end: cmd.item.z_hi};
    if (op_re) op_rd_r <= op_mem[oi_r[OIW-1:0]];
  end

  // piece lists
  always_ff @(posedge clk) begin
    if (pw_en && !pw_bank) pa_mem[pw_addr] <= pw_data;
    if (pw_en && pw_bank)  pb_mem[pw_addr] <= pw_data;
    if (pc_re) begin
      pa_rd_r <= pa_mem[j_r[PIW-1:0]];
      pb_rd_r <= pb_mem[j_r[PIW-1:0]];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scp_checker.sv =====
// ----------------------------------------------------------------------------
// scp_checker: port-level checks for the span clipper
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scp_checker
  import scp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_full,
  input wire logic      out_pop,
  input wire logic      out_empty,
  input wire out_item_t out_item
);

  // a result held while not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("result changed while waiting");

  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // an empty result always closes its query
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.has_piece) |-> out_item.last_piece)
    else $error("empty result without last mark");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.has_piece) |->
      (out_item.piece_start == '0 && out_item.piece_end == '0))
    else $error("empty result carries bounds");

  // dropped flag is sticky across results
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.openings_dropped) |=>
      (out_empty || out_item.openings_dropped))
    else $error("dropped flag fell");

endmodule

bind span_clip_against_rectangles scp_checker u_scp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_item  (out_item)
);
`default_nettype wire
